>>> sv/lrect_pkg.sv
// shared types and constants for the largest all-ones rectangle finder
`default_nettype none
package lrect_pkg;

  localparam int unsigned ROW_W_W = 11;
  localparam int unsigned AREA_W = 21;
  localparam logic [ROW_W_W-1:0] ROW_W_RESET = 11'd1024;
  localparam logic [AREA_W-1:0] AREA_MAX = 21'h1FFFFF;

  typedef struct packed {
    logic accept;
    logic pop;
    logic push;
    logic flush_pop;
    logic row_done;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic pop_ok;
    logic depth_zero;
    logic row_end;
    logic frame_end;
    logic score_busy;
    logic out_busy;
  } dp_status_t;

endpackage
`default_nettype wire

>>> sv/lrect_ifs.sv
// valid/ready channel interfaces for pixels, results and the width register
`default_nettype none
interface lrect_in_if;
  logic valid;
  logic ready;
  logic pixel;
  logic frame_end;
  modport source (output valid, output pixel, output frame_end, input ready);
  modport sink (input valid, input pixel, input frame_end, output ready);
endinterface

interface lrect_out_if;
  logic valid;
  logic ready;
  logic [lrect_pkg::AREA_W-1:0] max_area;
  modport source (output valid, output max_area, input ready);
  modport sink (input valid, input max_area, output ready);
endinterface

interface lrect_cfg_if;
  logic valid;
  logic ready;
  logic [lrect_pkg::ROW_W_W-1:0] row_width;
  modport source (output valid, output row_width, input ready);
  modport sink (input valid, input row_width, output ready);
endinterface
`default_nettype wire

>>> sv/lrect_ctrl.sv
// sequencing state machine: pixel update, pop loop, row flush, result emit
`default_nettype none
module lrect_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire lrect_pkg::dp_status_t  st,
  output lrect_pkg::ctrl_cmd_t        cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_FLUSH,
    S_DRAIN,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_POP;
        end
      end
      S_POP: begin
        if (st.pop_ok) begin
          cmd.pop = 1'b1;
        end else begin
          cmd.push  = 1'b1;
          state_nxt = st.row_end ? S_FLUSH : S_IDLE;
        end
      end
      S_FLUSH: begin
        if (!st.depth_zero) begin
          cmd.flush_pop = 1'b1;
        end else begin
          cmd.row_done = 1'b1;
          state_nxt    = st.frame_end ? S_DRAIN : S_IDLE;
        end
      end
      // let the last scores land in the best area
      S_DRAIN: begin
        if (!st.score_busy) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!st.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

>>> sv/lrect_dp.sv
// datapath: column heights, bar stack with cached top, area scoring, result register
`default_nettype none
module lrect_dp #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire lrect_pkg::ctrl_cmd_t                 cmd,
  output lrect_pkg::dp_status_t                     st,
  input  wire logic                                 in_pixel,
  input  wire logic                                 in_frame_end,
  input  wire logic                                 cfg_valid,
  input  wire logic [lrect_pkg::ROW_W_W-1:0]        cfg_row_width,
  input  wire logic                                 out_ready,
  output logic                                      out_valid,
  output logic [lrect_pkg::AREA_W-1:0]              out_max_area
);

  localparam int CIW = $clog2(MAX_COLS);
  localparam int CW1 = $clog2(MAX_COLS + 1);
  localparam int HW  = $clog2(MAX_ROWS + 1);
  localparam int WW  = (CW1 > lrect_pkg::ROW_W_W) ? CW1 : lrect_pkg::ROW_W_W;
  localparam int PW  = CW1 + HW;
  localparam int EW  = (PW > lrect_pkg::AREA_W) ? PW : lrect_pkg::AREA_W + 1;
  localparam int SW  = CIW + HW;

  // storage
  logic [HW-1:0] hgt_mem [MAX_COLS];
  logic [SW-1:0] stk_mem [MAX_COLS];

  // control registers
  logic [lrect_pkg::ROW_W_W-1:0] row_width_r;
  logic [CIW-1:0]                col_idx_r;
  logic [CW1-1:0]                fill_r;
  logic [CW1-1:0]                depth_r;
  logic                          first_r;
  logic                          prod_v_r;
  logic                          byp_v_r;
  logic [lrect_pkg::AREA_W-1:0]  best_r;
  logic                          out_v_r;

  // payload registers
  logic [CW1-1:0]                width_r;
  logic [CIW-1:0]                col_r;
  logic                          pix_r;
  logic                          fend_r;
  logic [HW-1:0]                 h_r;
  logic [CIW-1:0]                last_r;
  logic [HW-1:0]                 hgt_rd_r;
  logic [CIW-1:0]                top_start_r;
  logic [HW-1:0]                 top_h_r;
  logic [SW-1:0]                 stk_rd_r;
  logic [SW-1:0]                 byp_data_r;
  logic [PW-1:0]                 prod_r;
  logic [lrect_pkg::AREA_W-1:0]  out_area_r;

  logic [WW-1:0]                 rw_ext;
  logic [CW1-1:0]                eff_width;
  logic [HW-1:0]                 hgt_src;
  logic [HW-1:0]                 h_calc;
  logic [HW-1:0]                 h_cur;
  logic [SW-1:0]                 below;
  logic [CW1-1:0]                col_p1;
  logic [CW1-1:0]                top_start_w;
  logic [CW1-1:0]                sc_span;
  logic                          sc_v;
  logic [EW-1:0]                 prod_ext;
  logic [lrect_pkg::AREA_W-1:0]  prod_sat;
  logic                          push_ok;
  logic [CW1-1:0]                depth_nxt;
  logic                          stk_we;
  logic [CIW-1:0]                stk_waddr;
  logic [CIW-1:0]                stk_raddr;
  logic [SW-1:0]                 stk_wdata;

  // width clamp: zero acts as one, too large acts as the column count
  always_comb begin
    rw_ext = WW'(row_width_r);
    if (rw_ext == '0) begin
      eff_width = CW1'(1);
    end else if (rw_ext > WW'(MAX_COLS)) begin
      eff_width = CW1'(MAX_COLS);
    end else begin
      eff_width = CW1'(rw_ext);
    end
  end

  // columns at or beyond the fill mark were not written this frame
  assign hgt_src = (CW1'(col_r) < fill_r) ? hgt_rd_r : '0;

  always_comb begin
    if (!pix_r) begin
      h_calc = '0;
    end else if (hgt_src < HW'(MAX_ROWS)) begin
      h_calc = HW'(hgt_src + 1'b1);
    end else begin
      h_calc = hgt_src;
    end
  end

  assign h_cur       = first_r ? h_calc : h_r;
  assign below       = byp_v_r ? byp_data_r : stk_rd_r;
  assign col_p1      = CW1'(col_r) + CW1'(1);
  assign top_start_w = CW1'(top_start_r);

  assign st.pop_ok     = (depth_r != '0) && (top_h_r >= h_cur);
  assign st.depth_zero = (depth_r == '0);
  assign st.row_end    = (col_p1 >= width_r);
  assign st.frame_end  = fend_r;
  assign st.score_busy = prod_v_r;
  assign st.out_busy   = out_v_r && !out_ready;

  // span of the bar being scored
  assign sc_v = cmd.pop || cmd.flush_pop;
  always_comb begin
    if (cmd.pop) begin
      sc_span = CW1'(col_r) - top_start_w;
    end else if (top_start_w < width_r) begin
      sc_span = width_r - top_start_w;
    end else begin
      sc_span = '0;
    end
  end

  assign prod_ext = EW'(prod_r);
  assign prod_sat = (prod_ext > EW'(lrect_pkg::AREA_MAX)) ? lrect_pkg::AREA_MAX
                                                          : prod_ext[lrect_pkg::AREA_W-1:0];

  // stack: top lives in registers, the rest in memory below it
  assign push_ok = cmd.push && (depth_r < CW1'(MAX_COLS));

  always_comb begin
    priority if (cmd.emit) begin
      depth_nxt = '0;
    end else if (sc_v) begin
      depth_nxt = depth_r - CW1'(1);
    end else if (push_ok) begin
      depth_nxt = depth_r + CW1'(1);
    end else begin
      depth_nxt = depth_r;
    end
  end

  assign stk_we    = push_ok && (depth_r != '0);
  assign stk_waddr = CIW'(depth_r - CW1'(1));
  assign stk_wdata = {top_start_r, top_h_r};
  // prefetch the entry under the next top
  assign stk_raddr = CIW'(depth_nxt - CW1'(2));

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    stk_rd_r   <= stk_mem[stk_raddr];
    byp_data_r <= stk_wdata;
  end

  always_ff @(posedge clk) begin
    if (first_r) begin
      hgt_mem[col_r] <= h_calc;
    end
    hgt_rd_r <= hgt_mem[col_idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r <= lrect_pkg::ROW_W_RESET;
      col_idx_r   <= '0;
      fill_r      <= '0;
      depth_r     <= '0;
      first_r     <= 1'b0;
      prod_v_r    <= 1'b0;
      byp_v_r     <= 1'b0;
      best_r      <= '0;
      out_v_r     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        row_width_r <= cfg_row_width;
      end
      first_r  <= cmd.accept;
      prod_v_r <= sc_v;
      byp_v_r  <= stk_we && (stk_waddr == stk_raddr);
      depth_r  <= depth_nxt;
      if (cmd.emit) begin
        col_idx_r <= '0;
        fill_r    <= '0;
        best_r    <= '0;
      end else begin
        if (cmd.push && !st.row_end) begin
          col_idx_r <= CIW'(col_p1);
        end else if (cmd.row_done) begin
          col_idx_r <= '0;
        end
        if (first_r && (CW1'(col_r) >= fill_r)) begin
          fill_r <= col_p1;
        end
        if (prod_v_r && (prod_sat > best_r)) begin
          best_r <= prod_sat;
        end
      end
      if (cmd.emit) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      width_r <= eff_width;
      col_r   <= col_idx_r;
      pix_r   <= in_pixel;
      fend_r  <= in_frame_end;
      last_r  <= col_idx_r;
    end else if (cmd.pop) begin
      last_r <= top_start_r;
    end
    if (first_r) begin
      h_r <= h_calc;
    end
    if (sc_v) begin
      top_start_r <= below[SW-1:HW];
      top_h_r     <= below[HW-1:0];
    end else if (push_ok) begin
      top_start_r <= last_r;
      top_h_r     <= h_cur;
    end
    prod_r <= PW'(sc_span) * PW'(top_h_r);
    if (cmd.emit) begin
      out_area_r <= best_r;
    end
  end

  assign out_valid    = out_v_r;
  assign out_max_area = out_area_r;

endmodule
`default_nettype wire

>>> sv/largest_rectangle_of_ones.sv
// top level: largest all-ones rectangle in a streamed binary image
//
// channel   dir  word                    handshake
// in_ch     in   pixel, frame_end        valid/ready
// out_ch    out  max_area (21 bits)      valid/ready
// cfg_ch    in   row_width (11 bits)     valid/ready, always ready
//
// a pixel is accepted, then pops every bar at least its height from the stack
// and pushes its own bar; a row end pops the bars left on the stack; frame end
// waits for the scoring pipe to drain and then loads the result register
// no clearing pass after reset: column heights are masked by a fill mark
// a held result stalls only the next frame end, not the pixel stream
`default_nettype none
module largest_rectangle_of_ones #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024
) (
  input wire logic    clk,
  input wire logic    rst_n,
  lrect_in_if.sink    in_ch,
  lrect_out_if.source out_ch,
  lrect_cfg_if.sink   cfg_ch
);

  lrect_pkg::ctrl_cmd_t cmd;
  lrect_pkg::dp_status_t st;
  logic in_ready;

  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;

  lrect_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  lrect_dp #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .st            (st),
    .in_pixel      (in_ch.pixel),
    .in_frame_end  (in_ch.frame_end),
    .cfg_valid     (cfg_ch.valid),
    .cfg_row_width (cfg_ch.row_width),
    .out_ready     (out_ch.ready),
    .out_valid     (out_ch.valid),
    .out_max_area  (out_ch.max_area)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ready) |=> !in_ready)
    else $error("pixel accepted while previous pixel in progress");

  a_emit_drained: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !st.score_busy)
    else $error("result loaded with a score still in flight");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.pop || cmd.flush_pop) |-> !st.depth_zero)
    else $error("pop from an empty bar stack");

  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_ch.valid)
    else $error("result not presented after emit");

endmodule
`default_nettype wire

>>> sim/tb_largest_rectangle_of_ones.sv
// testbench for the largest all-ones rectangle finder: streamed frames checked against a predictor
`timescale 1ns / 100ps
module tb_largest_rectangle_of_ones;

  localparam int MAX_COLS = 1024;
  localparam int MAX_ROWS = 1024;
  localparam int QUIET_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n;

  always #4 clk = ~clk;

  lrect_in_if  in_ch ();
  lrect_out_if out_ch ();
  lrect_cfg_if cfg_ch ();

  largest_rectangle_of_ones u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // predictor state
  logic [lrect_pkg::ROW_W_W-1:0] width_reg;
  int unsigned                   col_height [MAX_COLS];
  int unsigned                   bar_start [MAX_COLS];
  int unsigned                   bar_height [MAX_COLS];
  int unsigned                   bar_depth;
  int unsigned                   col_pos;
  logic [lrect_pkg::AREA_W-1:0]  area_best;

  logic [lrect_pkg::AREA_W-1:0]  pending_areas [$];
  logic [lrect_pkg::AREA_W-1:0]  want_area;
  int                            mismatch_count = 0;
  int                            quiet_cycles = 0;
  int                            pixels_sent = 0;
  bit                            in_calm = 1'b0;
  bit                            out_calm = 1'b0;

  function automatic int pick_gap(inout bit calm);
    if ($urandom_range(0, 39) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 6);
  endfunction

  function automatic int unsigned eff_width();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_COLS) return MAX_COLS;
    return 32'(width_reg);
  endfunction

  function automatic void clear_frame();
    for (int i = 0; i < MAX_COLS; i++) col_height[i] = 0;
    bar_depth = 0;
    col_pos = 0;
    area_best = '0;
  endfunction

  function automatic void score_bar(input int unsigned span, input int unsigned h);
    longint unsigned a;
    a = span;
    a = a * h;
    if (a > lrect_pkg::AREA_MAX) a = lrect_pkg::AREA_MAX;
    if (a > area_best) area_best = a[lrect_pkg::AREA_W-1:0];
  endfunction

  // advances the column heights and bar stack by one pixel; 1 when a frame area comes out
  function automatic bit scan_pixel(input logic px, input logic fe,
                                    output logic [lrect_pkg::AREA_W-1:0] area);
    int unsigned wd, col, h, last, span;
    area = '0;
    wd = eff_width();
    col = col_pos;
    if (col >= MAX_COLS) col = MAX_COLS - 1;
    if (px) begin
      h = col_height[col];
      if (h < MAX_ROWS) h++;
    end else begin
      h = 0;
    end
    col_height[col] = h;

    last = col;
    while (bar_depth > 0 && bar_height[bar_depth-1] >= h) begin
      last = bar_start[bar_depth-1];
      score_bar(col - last, bar_height[bar_depth-1]);
      bar_depth--;
    end
    if (bar_depth < MAX_COLS) begin
      bar_start[bar_depth] = last;
      bar_height[bar_depth] = h;
      bar_depth++;
    end

    if (col + 1 < wd) begin
      col_pos = col + 1;
      return 1'b0;
    end

    // row end: bars starting past a shrunken width score nothing
    while (bar_depth > 0) begin
      span = (bar_start[bar_depth-1] < wd) ? wd - bar_start[bar_depth-1] : 0;
      score_bar(span, bar_height[bar_depth-1]);
      bar_depth--;
    end
    col_pos = 0;
    if (!fe) return 1'b0;
    area = area_best;
    clear_frame();
    return 1'b1;
  endfunction

  task automatic send_pixel(input logic px, input logic fe);
    int gap;
    logic [lrect_pkg::AREA_W-1:0] area;
    gap = pick_gap(in_calm);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.pixel <= px;
    in_ch.frame_end <= fe;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    if (scan_pixel(px, fe, area)) pending_areas.push_back(area);
    pixels_sent++;
  endtask

  // no word in flight and enough cycles for the last row flush to finish
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_areas.size() != 0) @(posedge clk);
    repeat (3 * eff_width() + 16) @(posedge clk);
  endtask

  task automatic write_width(input logic [lrect_pkg::ROW_W_W-1:0] w);
    settle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.row_width <= w;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    width_reg = w;
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // dens is the chance of a set pixel in eighths; noisy adds stray frame ends
  task automatic send_frame(input int rows, input int dens, input bit noisy);
    int wd;
    bit px, fe, last_one;
    wd = eff_width();
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < wd; c++) begin
        last_one = (r == rows - 1) && (c == wd - 1);
        px = $urandom_range(0, 7) < dens;
        fe = last_one || (noisy && $urandom_range(0, 15) == 0);
        send_pixel(px, fe);
      end
    end
  endtask

  // the reset width keeps the row open; a narrow width then closes it
  task automatic test_reset_width();
    repeat (24) send_pixel($urandom_range(0, 7) < 6, 1'b0);
    write_width(11'd3);
    send_pixel(1'b1, 1'b1);
  endtask

  task automatic test_directed();
    write_width(11'd4);
    send_pixel(1'b1, 1'b0);
    send_pixel(1'b1, 1'b1);   // frame end mid-row, ignored
    send_pixel(1'b0, 1'b0);
    send_pixel(1'b1, 1'b0);
    send_pixel(1'b1, 1'b0);
    send_pixel(1'b1, 1'b0);
    send_pixel(1'b1, 1'b0);
    send_pixel(1'b1, 1'b1);
    // empty frame
    repeat (3) send_pixel(1'b0, 1'b0);
    send_pixel(1'b0, 1'b1);
    // zero width acts as one column
    write_width(11'd0);
    send_pixel(1'b1, 1'b1);
    send_pixel(1'b0, 1'b1);
    // width shrinks mid-row, leaving a bar past the new row end
    write_width(11'd6);
    send_pixel(1'b0, 1'b0);
    send_pixel(1'b0, 1'b0);
    send_pixel(1'b0, 1'b0);
    send_pixel(1'b1, 1'b0);
    write_width(11'd2);
    send_pixel(1'b1, 1'b1);
  endtask

  // heights rise left to right on the last row so the flush empties a deep stack
  task automatic test_staircase();
    write_width(11'd12);
    for (int r = 0; r < 12; r++) begin
      for (int c = 0; c < 12; c++) send_pixel(r >= 11 - c, (r == 11) && (c == 11));
    end
  endtask

  // an oversized width keeps the row open like the largest width
  task automatic test_width_clamp();
    write_width(11'd2047);
    repeat (16) send_pixel($urandom_range(0, 7) < 7, 1'b0);
    write_width(11'd1024);
    repeat (16) send_pixel($urandom_range(0, 7) < 5, 1'b0);
    write_width(11'd1);
    send_pixel(1'b1, 1'b1);
  endtask

  task automatic test_random_frames();
    write_width(11'd5);
    while (pixels_sent < 750) begin
      if ($urandom_range(0, 5) == 0) begin
        if ($urandom_range(0, 9) == 0) write_width(11'($urandom_range(17, 48)));
        else write_width(11'($urandom_range(0, 12)));
      end
      send_frame($urandom_range(1, 6), $urandom_range(0, 8), $urandom_range(0, 3) == 0);
    end
  endtask

  // result sink: ready either stays up or is held back for a drawn number of cycles
  initial begin : area_sink
    int stall;
    forever begin
      stall = pick_gap(out_calm);
      if (stall == 0) begin
        out_ch.ready <= 1'b1;
        do @(posedge clk); while (out_ch.valid !== 1'b1);
      end else begin
        out_ch.ready <= 1'b0;
        do @(posedge clk); while (out_ch.valid !== 1'b1);
        repeat (stall - 1) @(posedge clk);
        out_ch.ready <= 1'b1;
        do @(posedge clk); while (out_ch.valid !== 1'b1);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_areas.size() == 0) begin
        $display("%0t: area word with none expected: expected none, actual %0d",
                 $time, out_ch.max_area);
        mismatch_count++;
      end else begin
        want_area = pending_areas.pop_front();
        if (out_ch.max_area !== want_area) begin
          $display("%0t: max_area expected %0d, actual %0d",
                   $time, want_area, out_ch.max_area);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) ||
        (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.pixel <= 1'b0;
    in_ch.frame_end <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.row_width <= '0;
    width_reg = lrect_pkg::ROW_W_RESET;
    clear_frame();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_width();
    test_directed();
    test_staircase();
    test_width_clamp();
    test_random_frames();

    settle();
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> files.f
sv/lrect_pkg.sv
sv/lrect_ifs.sv
sv/lrect_ctrl.sv
sv/lrect_dp.sv
sv/largest_rectangle_of_ones.sv
sim/tb_largest_rectangle_of_ones.sv
